>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and fixed-point helpers of the sprite quad generator.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int MAX_SPRITES = 16384;
    localparam int VERT_WRAP   = 4 * MAX_SPRITES;
    localparam int VCOUNT_W    = $clog2(VERT_WRAP);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = 48;
    localparam int DIVCNT_W    = $clog2(DIV_STEPS);

    localparam logic [30:0] ASPECT_ONE  = 31'h0001_0000;
    localparam logic [1:0]  CORNER_LAST = 2'd3;
    localparam logic [1:0]  CORNER_TL   = 2'd0;

    typedef struct packed {
        logic signed [31:0] half_w;
        logic signed [31:0] half_h;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] trim_scale_x;
        logic signed [31:0] trim_scale_y;
        logic signed [31:0] trim_shift_x;
        logic signed [31:0] trim_shift_y;
        logic [30:0]        aspect;
        logic [63:0]        tex_rect;
        logic [2:0]         sprite_flags;
        logic [15:0]        tex_id;
    } sprite_t;

    typedef struct packed {
        logic [15:0]        vert_index;
        logic [1:0]         corner;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic               batch_start;
        logic               quad_last;
    } vertex_t;

    typedef enum logic [1:0] {
        DERIVE_NONE,
        DERIVE_H,
        DERIVE_W
    } derive_mode_t;

    // One classified sprite waiting for the back end.
    typedef struct packed {
        logic signed [31:0] half_w;
        logic signed [31:0] half_h;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] trim_scale_x;
        logic signed [31:0] trim_scale_y;
        logic signed [31:0] trim_shift_x;
        logic signed [31:0] trim_shift_y;
        logic [30:0]        aspect;
        logic [63:0]        tex_rect;
        logic               flip_x;
        logic               flip_y;
        logic               last;
        logic               batch_start;
        derive_mode_t       mode;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_FULL,
        BK_MUL,
        BK_WB,
        BK_EMIT
    } back_state_t;

    typedef enum logic [2:0] {
        OP_DERIVE_W,
        OP_PX,
        OP_PY,
        OP_HW,
        OP_HH,
        OP_OX,
        OP_OY
    } mul_op_t;

    // Saturate a 48-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 product: divide by 2^16 rounding toward zero, then saturate.
    function automatic logic signed [31:0] q_scale(input logic signed [63:0] prod);
        logic signed [63:0] adj;
        logic signed [63:0] shr;
        adj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
        shr = adj >>> 16;
        return sat48(shr[47:0]);
    endfunction

endpackage

>>> src/spq_front.sv
// ----------------------------------------------------------------------------
// spq_front
// Accepts sprites, picks the size derivation and tracks texture batches.
// ----------------------------------------------------------------------------
module spq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sprite_valid,
    output logic                sprite_ready,
    input  spq_pkg::sprite_t    sprite,
    input  spq_pkg::q_status_t  qstat,
    output logic                push,
    output spq_pkg::job_t       job
);

    logic        batch_open_reg;
    logic        batch_open_next;
    logic [15:0] prev_tex_reg;
    logic [15:0] prev_tex_next;

    assign sprite_ready = !qstat.full;
    assign push         = sprite_valid && sprite_ready;

    always_comb
    begin
        job.half_w       = sprite.half_w;
        job.half_h       = sprite.half_h;
        job.pivot_x      = sprite.pivot_x;
        job.pivot_y      = sprite.pivot_y;
        job.trim_scale_x = sprite.trim_scale_x;
        job.trim_scale_y = sprite.trim_scale_y;
        job.trim_shift_x = sprite.trim_shift_x;
        job.trim_shift_y = sprite.trim_shift_y;
        job.aspect       = (sprite.aspect == '0) ? spq_pkg::ASPECT_ONE : sprite.aspect;
        job.tex_rect     = sprite.tex_rect;
        job.flip_x       = sprite.sprite_flags[0];
        job.flip_y       = sprite.sprite_flags[1];
        job.last         = sprite.sprite_flags[2];
        job.batch_start  = !batch_open_reg || (sprite.tex_id != prev_tex_reg);
        // A height of zero or less wins over a nonpositive width.
        if (sprite.half_h[31] || sprite.half_h == '0) begin
            job.mode = spq_pkg::DERIVE_H;
        end else if (sprite.half_w[31] || sprite.half_w == '0) begin
            job.mode = spq_pkg::DERIVE_W;
        end else begin
            job.mode = spq_pkg::DERIVE_NONE;
        end
    end

    always_comb
    begin
        batch_open_next = batch_open_reg;
        prev_tex_next   = prev_tex_reg;
        if (push) begin
            batch_open_next = !sprite.sprite_flags[2];
            prev_tex_next   = sprite.tex_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            batch_open_reg <= 1'b0;
            prev_tex_reg   <= '0;
        end else begin
            batch_open_reg <= batch_open_next;
            prev_tex_reg   <= prev_tex_next;
        end
    end

endmodule

>>> src/spq_queue.sv
// ----------------------------------------------------------------------------
// spq_queue
// Short FIFO of classified sprites between the front and back ends.
// ----------------------------------------------------------------------------
module spq_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spq_pkg::job_t       wr_job,
    input  logic                pop,
    output spq_pkg::job_t       head,
    output spq_pkg::q_status_t  qstat
);

    spq_pkg::job_t                entries_reg [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [spq_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [spq_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [spq_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [spq_pkg::QCNT_W-1:0]   count_reg;
    logic [spq_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    localparam logic [spq_pkg::QPTR_W-1:0] PTR_LAST = spq_pkg::QPTR_W'(spq_pkg::QUEUE_DEPTH - 1);
    localparam logic [spq_pkg::QCNT_W-1:0] CNT_FULL = spq_pkg::QCNT_W'(spq_pkg::QUEUE_DEPTH);

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> src/spq_div.sv
// ----------------------------------------------------------------------------
// spq_div
// Bit-serial Q16.16 divider of a signed half size by the positive aspect.
// ----------------------------------------------------------------------------
module spq_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  dividend,
    input  logic [30:0]         divisor,
    output logic                done,
    output logic signed [31:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [spq_pkg::DIVCNT_W-1:0]  cnt_reg;
    logic [47:0]                   bits_reg;
    logic [30:0]                   rem_reg;
    logic [30:0]                   dsr_reg;
    logic                          neg_reg;
    logic [31:0]                   mag;
    logic [31:0]                   trial;
    logic                          fits;
    logic signed [48:0]            signed_q;

    assign mag   = dividend[31] ? (~dividend + 32'd1) : dividend;
    assign trial = {rem_reg, bits_reg[47]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // The magnitude quotient is at most 2^47, so 49 signed bits hold it.
    assign signed_q = neg_reg ? -$signed({1'b0, bits_reg}) : $signed({1'b0, bits_reg});
    assign quotient = spq_pkg::sat48(signed_q[47:0]);
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= spq_pkg::DIVCNT_W'(spq_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            bits_reg <= {mag, 16'h0000};
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            neg_reg  <= dividend[31];
        end else if (busy_reg) begin
            bits_reg <= {bits_reg[46:0], fits};
            rem_reg  <= fits ? 31'(trial - {1'b0, dsr_reg}) : trial[30:0];
        end
    end

endmodule

>>> src/spq_back.sv
// ----------------------------------------------------------------------------
// spq_back
// Computes the quad geometry of one sprite and emits its four vertices.
// ----------------------------------------------------------------------------
module spq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::q_status_t  qstat,
    input  spq_pkg::job_t       head,
    output logic                pop,
    output logic                vert_valid,
    input  logic                vert_ready,
    output spq_pkg::vertex_t    vert
);

    spq_pkg::back_state_t           state_reg;
    spq_pkg::back_state_t           state_next;
    spq_pkg::mul_op_t               op_reg;
    spq_pkg::mul_op_t               op_next;
    spq_pkg::job_t                  job_reg;
    logic signed [31:0]             hw_reg;
    logic signed [31:0]             hh_reg;
    logic signed [31:0]             fw_reg;
    logic signed [31:0]             fh_reg;
    logic signed [31:0]             px_reg;
    logic signed [31:0]             py_reg;
    logic signed [31:0]             ox_reg;
    logic signed [31:0]             oy_reg;
    logic signed [63:0]             prod_reg;
    logic [1:0]                     corner_reg;
    logic [spq_pkg::VCOUNT_W-1:0]   vcount_reg;
    logic [spq_pkg::VCOUNT_W-1:0]   vcount_next;
    spq_pkg::vertex_t               out_reg;
    logic                           out_valid_reg;

    logic                           load_vert;
    logic                           div_start;
    logic                           div_done;
    logic signed [31:0]             div_q;
    logic signed [31:0]             mul_a;
    logic signed [31:0]             mul_b;
    logic signed [31:0]             mul_res;
    logic signed [33:0]             pos_x_wide;
    logic signed [33:0]             pos_y_wide;
    logic signed [32:0]             fw_wide;
    logic signed [32:0]             fh_wide;
    spq_pkg::vertex_t               vert_new;

    localparam logic [spq_pkg::VCOUNT_W-1:0] VCOUNT_LAST =
        spq_pkg::VCOUNT_W'(spq_pkg::VERT_WRAP - 1);

    spq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (head.half_w),
        .divisor  (head.aspect),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::BK_IDLE:
            begin
                if (!qstat.empty) begin
                    case (head.mode)
                        spq_pkg::DERIVE_H: state_next = spq_pkg::BK_DIV;
                        spq_pkg::DERIVE_W: state_next = spq_pkg::BK_MUL;
                        default:           state_next = spq_pkg::BK_FULL;
                    endcase
                end
            end
            spq_pkg::BK_DIV:
            begin
                if (div_done) begin
                    state_next = spq_pkg::BK_FULL;
                end
            end
            spq_pkg::BK_FULL: state_next = spq_pkg::BK_MUL;
            spq_pkg::BK_MUL:  state_next = spq_pkg::BK_WB;
            spq_pkg::BK_WB:
            begin
                case (op_reg)
                    spq_pkg::OP_DERIVE_W: state_next = spq_pkg::BK_FULL;
                    spq_pkg::OP_OY:       state_next = spq_pkg::BK_EMIT;
                    default:              state_next = spq_pkg::BK_MUL;
                endcase
            end
            spq_pkg::BK_EMIT:
            begin
                if (load_vert && corner_reg == spq_pkg::CORNER_LAST) begin
                    state_next = spq_pkg::BK_IDLE;
                end
            end
            default: state_next = spq_pkg::BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop       = (state_reg == spq_pkg::BK_IDLE) && !qstat.empty;
        div_start = pop && (head.mode == spq_pkg::DERIVE_H);
        load_vert = (state_reg == spq_pkg::BK_EMIT) && (!out_valid_reg || vert_ready);
        case (state_reg)
            spq_pkg::BK_IDLE: op_next = spq_pkg::OP_DERIVE_W;
            spq_pkg::BK_FULL: op_next = spq_pkg::OP_PX;
            spq_pkg::BK_WB:
            begin
                case (op_reg)
                    spq_pkg::OP_PX: op_next = spq_pkg::OP_PY;
                    spq_pkg::OP_PY: op_next = spq_pkg::OP_HW;
                    spq_pkg::OP_HW: op_next = spq_pkg::OP_HH;
                    spq_pkg::OP_HH: op_next = spq_pkg::OP_OX;
                    spq_pkg::OP_OX: op_next = spq_pkg::OP_OY;
                    default:        op_next = op_reg;
                endcase
            end
            default: op_next = op_reg;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (op_reg)
            spq_pkg::OP_DERIVE_W:
            begin
                mul_a = hh_reg;
                mul_b = $signed({1'b0, job_reg.aspect});
            end
            spq_pkg::OP_PX:
            begin
                mul_a = job_reg.pivot_x;
                mul_b = fw_reg;
            end
            spq_pkg::OP_PY:
            begin
                mul_a = job_reg.pivot_y;
                mul_b = fh_reg;
            end
            spq_pkg::OP_HW:
            begin
                mul_a = hw_reg;
                mul_b = job_reg.trim_scale_x;
            end
            spq_pkg::OP_HH:
            begin
                mul_a = hh_reg;
                mul_b = job_reg.trim_scale_y;
            end
            spq_pkg::OP_OX:
            begin
                mul_a = job_reg.trim_shift_x;
                mul_b = fw_reg;
            end
            default:
            begin
                mul_a = job_reg.trim_shift_y;
                mul_b = fh_reg;
            end
        endcase
    end

    assign mul_res = spq_pkg::q_scale(prod_reg);
    assign fw_wide = {hw_reg, 1'b0};
    assign fh_wide = {hh_reg, 1'b0};

    // Corner positions are formed exactly in 34 bits and saturated once.
    always_comb
    begin
        logic signed [33:0] hx;
        logic signed [33:0] hy;
        logic               ur;
        logic               vb;
        hx = {{2{hw_reg[31]}}, hw_reg};
        hy = {{2{hh_reg[31]}}, hh_reg};
        ur = corner_reg[0] ^ job_reg.flip_x;
        vb = corner_reg[1] ^ job_reg.flip_y;
        pos_x_wide = (corner_reg[0] ? hx : -hx)
                   - {{2{px_reg[31]}}, px_reg} + {{2{ox_reg[31]}}, ox_reg};
        pos_y_wide = (corner_reg[1] ? -hy : hy)
                   - {{2{py_reg[31]}}, py_reg} + {{2{oy_reg[31]}}, oy_reg};
        vert_new.vert_index  = 16'(vcount_reg);
        vert_new.corner      = corner_reg;
        vert_new.pos_x       = spq_pkg::sat48({{14{pos_x_wide[33]}}, pos_x_wide});
        vert_new.pos_y       = spq_pkg::sat48({{14{pos_y_wide[33]}}, pos_y_wide});
        vert_new.tex_u       = ur ? job_reg.tex_rect[47:32] : job_reg.tex_rect[15:0];
        vert_new.tex_v       = vb ? job_reg.tex_rect[63:48] : job_reg.tex_rect[31:16];
        vert_new.batch_start = (corner_reg == spq_pkg::CORNER_TL) && job_reg.batch_start;
        vert_new.quad_last   = (corner_reg == spq_pkg::CORNER_LAST);
    end

    // The last sprite of a list restarts the count after its fourth vertex.
    always_comb
    begin
        vcount_next = vcount_reg;
        if (load_vert) begin
            if (corner_reg == spq_pkg::CORNER_LAST && job_reg.last) begin
                vcount_next = '0;
            end else if (vcount_reg == VCOUNT_LAST) begin
                vcount_next = '0;
            end else begin
                vcount_next = vcount_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= spq_pkg::BK_IDLE;
            op_reg        <= spq_pkg::OP_DERIVE_W;
            corner_reg    <= '0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            vcount_reg <= vcount_next;
            if (pop) begin
                corner_reg <= '0;
            end else if (load_vert) begin
                corner_reg <= corner_reg + 1'b1;
            end
            if (load_vert) begin
                out_valid_reg <= 1'b1;
            end else if (vert_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            job_reg <= head;
            hw_reg  <= head.half_w;
            hh_reg  <= head.half_h;
        end
        if (state_reg == spq_pkg::BK_DIV && div_done) begin
            hh_reg <= div_q;
        end
        if (state_reg == spq_pkg::BK_FULL) begin
            fw_reg <= spq_pkg::sat48({{15{fw_wide[32]}}, fw_wide});
            fh_reg <= spq_pkg::sat48({{15{fh_wide[32]}}, fh_wide});
        end
        if (state_reg == spq_pkg::BK_MUL) begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == spq_pkg::BK_WB) begin
            case (op_reg)
                spq_pkg::OP_DERIVE_W: hw_reg <= mul_res;
                spq_pkg::OP_PX:       px_reg <= mul_res;
                spq_pkg::OP_PY:       py_reg <= mul_res;
                spq_pkg::OP_HW:       hw_reg <= mul_res;
                spq_pkg::OP_HH:       hh_reg <= mul_res;
                spq_pkg::OP_OX:       ox_reg <= mul_res;
                default:              oy_reg <= mul_res;
            endcase
        end
        if (load_vert) begin
            out_reg <= vert_new;
        end
    end

    assign vert_valid = out_valid_reg;
    assign vert       = out_reg;

endmodule

>>> src/sprite_quad_generation.sv
// ----------------------------------------------------------------------------
// sprite_quad_generation
// Turns one sprite item into four Q16.16 corner vertex items.
// ----------------------------------------------------------------------------
// A sprite is taken into a two-entry queue as soon as there is room, so the
// input side keeps moving while the back end works. The back end handles one
// sprite at a time with a single shared 32x32 multiplier, registering each
// product before writing it back; a sprite whose width is derived from the
// height needs one more product, and one whose height is derived by division
// first waits on the bit-serial divider (48 steps). Its four vertices then
// leave at one per cycle through a registered output stage while the output
// side keeps taking them.
module sprite_quad_generation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sprite_valid,
    output logic               sprite_ready,
    input  spq_pkg::sprite_t   sprite,
    output logic               vert_valid,
    input  logic               vert_ready,
    output spq_pkg::vertex_t   vert
);

    spq_pkg::q_status_t qstat;
    spq_pkg::job_t      wr_job;
    spq_pkg::job_t      head;
    logic               push;
    logic               pop;

    spq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .sprite       (sprite),
        .qstat        (qstat),
        .push         (push),
        .job          (wr_job)
    );

    spq_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .head   (head),
        .qstat  (qstat)
    );

    spq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .head       (head),
        .pop        (pop),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sprite_quad_generation. Sprite items are driven on
// a valid/ready channel, and a scoreboard predicts the four corner vertex
// items of each sprite (size derivation, Q16.16 saturating math, texture
// flips, batch and list tracking) and checks them field by field as they
// leave. Directed corner cases come first, then random sprite lists under
// changing idle patterns.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS  = 360;
    localparam int          DRAIN_CYCLES  = 200;
    // About 380 sprites; even at the slow division path plus long output
    // stalls this stays well below the limit.
    localparam int          MAX_CYCLES    = 500_000;
    localparam int          MAX_REPORTS   = 100;

    localparam logic [2:0]  SPR_FLIP_X    = 3'b001;
    localparam logic [2:0]  SPR_FLIP_Y    = 3'b010;
    localparam logic [2:0]  SPR_LAST      = 3'b100;

    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [31:0] Q_HALF        = 32'h0000_8000;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;
    localparam logic [30:0] ASPECT_MAX    = 31'h7FFF_FFFF;

    class quad_scoreboard;
        spq_pkg::vertex_t expected_verts[$];
        int          vert_count;
        logic [15:0] last_tex;
        bit          batch_open;
        int          errors;
        int          n_sprites;
        int          n_verts;
        int          n_batches;
        int          n_div;
        int          n_mul;
        int          n_lists;
        int          n_wraps;

        function new();
            vert_count = 0;
            last_tex   = '0;
            batch_open = 1'b0;
            errors     = 0;
            n_sprites  = 0;
            n_verts    = 0;
            n_batches  = 0;
            n_div      = 0;
            n_mul      = 0;
            n_lists    = 0;
            n_wraps    = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Q16.16 product and quotient, both truncating toward zero.
        function longint q_mul(longint a, longint b);
            return clamp32((a * b) / 65536);
        endfunction

        function longint q_div(longint a, longint b);
            return clamp32((a * 65536) / b);
        endfunction

        function void note_sprite(spq_pkg::sprite_t s);
            longint  hw, hh, asp, fw, fh, px, py, ox, oy, x, y;
            bit      start, right, bottom;
            spq_pkg::vertex_t v;
            hw  = longint'($signed(s.half_w));
            hh  = longint'($signed(s.half_h));
            asp = longint'(s.aspect);
            if (asp == 0)
                asp = 65536;
            if (hh <= 0) begin
                hh = q_div(hw, asp);
                n_div++;
            end else if (hw <= 0) begin
                hw = q_mul(hh, asp);
                n_mul++;
            end
            fw = clamp32(hw * 2);
            fh = clamp32(hh * 2);
            px = q_mul(longint'($signed(s.pivot_x)), fw);
            py = q_mul(longint'($signed(s.pivot_y)), fh);
            hw = q_mul(hw, longint'($signed(s.trim_scale_x)));
            hh = q_mul(hh, longint'($signed(s.trim_scale_y)));
            ox = q_mul(longint'($signed(s.trim_shift_x)), fw);
            oy = q_mul(longint'($signed(s.trim_shift_y)), fh);

            start      = !batch_open || (s.tex_id != last_tex);
            last_tex   = s.tex_id;
            batch_open = 1'b1;
            if (start)
                n_batches++;

            for (int k = 0; k < 4; k++) begin
                right  = k[0];
                bottom = k[1];
                x = (right ? hw : -hw) - px + ox;
                y = (bottom ? -hh : hh) - py + oy;
                v.vert_index  = vert_count[15:0];
                v.corner      = k[1:0];
                v.pos_x       = clamp32(x);
                v.pos_y       = clamp32(y);
                v.tex_u       = (right != ((s.sprite_flags & SPR_FLIP_X) != 0)) ?
                                s.tex_rect[47:32] : s.tex_rect[15:0];
                v.tex_v       = (bottom != ((s.sprite_flags & SPR_FLIP_Y) != 0)) ?
                                s.tex_rect[63:48] : s.tex_rect[31:16];
                v.batch_start = (v.corner == spq_pkg::CORNER_TL) && start;
                v.quad_last   = (v.corner == spq_pkg::CORNER_LAST);
                expected_verts.push_back(v);
                vert_count++;
                if (vert_count >= spq_pkg::VERT_WRAP) begin
                    vert_count = 0;
                    n_wraps++;
                end
            end

            if ((s.sprite_flags & SPR_LAST) != 0) begin
                vert_count = 0;
                batch_open = 1'b0;
                n_lists++;
            end
            n_sprites++;
        endfunction

        function void compare(string fname, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: %s mismatch, expected %h, actual %h",
                             $time, fname, exp_v, act_v);
                else if (errors == MAX_REPORTS + 1)
                    $display("%0t ns: further mismatches are counted but not shown",
                             $time);
            end
        endfunction

        function void check_vertex(spq_pkg::vertex_t v);
            spq_pkg::vertex_t e;
            if (expected_verts.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected vertex item, expected none, actual %h",
                             $time, v);
                return;
            end
            e = expected_verts.pop_front();
            compare("vert_index", 32'(e.vert_index), 32'(v.vert_index));
            compare("corner", 32'(e.corner), 32'(v.corner));
            compare("pos_x", e.pos_x, v.pos_x);
            compare("pos_y", e.pos_y, v.pos_y);
            compare("tex_u", 32'(e.tex_u), 32'(v.tex_u));
            compare("tex_v", 32'(e.tex_v), 32'(v.tex_v));
            compare("batch_start", 32'(e.batch_start), 32'(v.batch_start));
            compare("quad_last", 32'(e.quad_last), 32'(v.quad_last));
            n_verts++;
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             sprite_valid;
    logic             sprite_ready;
    spq_pkg::sprite_t sprite;
    logic             vert_valid;
    logic             vert_ready;
    spq_pkg::vertex_t vert;

    quad_scoreboard sb = new();
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    logic [15:0]    list_tex = 16'h0001;

    sprite_quad_generation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .sprite       (sprite),
        .vert_valid   (vert_valid),
        .vert_ready   (vert_ready),
        .vert         (vert)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= MAX_CYCLES);
        $display("timeout after %0d cycles, %0d vertex items still expected",
                 cycle_count, sb.expected_verts.size());
        $display("FAIL sprite_quad_generation");
        $finish;
    end

    // Output side: check on each accepted vertex item, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && vert_valid && vert_ready)
            sb.check_vertex(vert);
        vert_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_sprite(input spq_pkg::sprite_t s);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sprite_valid <= 1'b0;
            @(posedge clk);
        end
        sprite_valid <= 1'b1;
        sprite       <= s;
        @(posedge clk);
        while (!sprite_ready)
            @(posedge clk);
        sb.note_sprite(s);
    endtask

    function automatic spq_pkg::sprite_t make_sprite(
        input logic [31:0] hw, input logic [31:0] hh,
        input logic [31:0] pvx, input logic [31:0] pvy,
        input logic [31:0] tsx, input logic [31:0] tsy,
        input logic [31:0] shx, input logic [31:0] shy,
        input logic [30:0] asp, input logic [63:0] rect,
        input logic [2:0] flags, input logic [15:0] tex);
        spq_pkg::sprite_t s;
        s.half_w       = hw;
        s.half_h       = hh;
        s.pivot_x      = pvx;
        s.pivot_y      = pvy;
        s.trim_scale_x = tsx;
        s.trim_scale_y = tsy;
        s.trim_shift_x = shx;
        s.trim_shift_y = shy;
        s.aspect       = asp;
        s.tex_rect     = rect;
        s.sprite_flags = flags;
        s.tex_id       = tex;
        return s;
    endfunction

    function automatic logic [31:0] rand_any();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            case ($urandom_range(0, 5))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return 32'h0;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h1;
                default: return Q_ONE;
            endcase
        end
        if (pick < 7)
            return $urandom;
        return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endfunction

    // Half sizes are mostly plausible, with zero, negative and wild values
    // mixed in so that both derivation paths and saturation come up.
    function automatic logic [31:0] rand_half();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 32'h0;
        if (pick < 18)
            return -$urandom_range(1, 32'h0100_0000);
        if (pick < 26)
            return rand_any();
        return $urandom_range(32'h0000_1000, 32'h0100_0000);
    endfunction

    function automatic logic [30:0] rand_aspect();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return 31'h0;
        if (pick < 8)
            return 31'h1;
        if (pick < 12)
            return ASPECT_MAX;
        if (pick < 30)
            return 31'($urandom);
        return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
    endfunction

    function automatic spq_pkg::sprite_t rand_sprite(input logic [2:0] flags,
                                                     input logic [15:0] tex);
        bit wild;
        wild = ($urandom_range(0, 99) < 20);
        return make_sprite(
            rand_half(), rand_half(),
            wild ? rand_any() : $urandom_range(0, Q_ONE),
            wild ? rand_any() : $urandom_range(0, Q_ONE),
            wild ? rand_any() : $urandom_range(32'h8000, 32'h1_8000),
            wild ? rand_any() : $urandom_range(32'h8000, 32'h1_8000),
            wild ? rand_any() : $urandom_range(0, 32'h2000) - 32'h1000,
            wild ? rand_any() : $urandom_range(0, 32'h2000) - 32'h1000,
            rand_aspect(), {$urandom, $urandom}, flags, tex);
    endfunction

    // One list: sprites sharing a texture for a while, closed by a last sprite.
    // Some items are pure noise with arbitrary flags and handles.
    task automatic send_random_list(inout int sent);
        int               len;
        logic [2:0]       flags;
        spq_pkg::sprite_t s;
        len = $urandom_range(1, 10);
        if ($urandom_range(0, 99) < 40)
            list_tex = ($urandom_range(0, 99) < 50) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom);
        for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
            if (sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 78;
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < 15) begin
                s = rand_sprite(3'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(0, 99) < 12)
                    list_tex = list_tex + 16'd1;
                flags = 3'($urandom_range(0, 3));
                if (k == len - 1)
                    flags = flags | SPR_LAST;
                s = rand_sprite(flags, list_tex);
            end
            send_sprite(s);
            sent++;
        end
    endtask

    initial
    begin
        int sent;
        rst_n        = 1'b0;
        sprite_valid = 1'b0;
        sprite       = '0;
        vert_ready   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 31;
        recv_idle_pct = 78;
        // Zero aspect with both half sizes zero, texture handle equal to the
        // reset handle: the first sprite must still open a batch.
        send_sprite(make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 31'h0, 64'h0, 3'b000, 16'h0000));
        send_sprite(make_sprite(32'h0010_0000, 32'h0008_0000, Q_HALF, Q_HALF, Q_ONE, Q_ONE,
                                0, 0, spq_pkg::ASPECT_ONE, 64'hF000_C000_4000_1000, 3'b000,
                                16'h0001));
        send_sprite(make_sprite(32'h0010_0000, 32'h0008_0000, Q_HALF, Q_HALF, Q_ONE, Q_ONE,
                                0, 0, spq_pkg::ASPECT_ONE, 64'hF000_C000_4000_1000,
                                SPR_FLIP_X, 16'h0001));
        send_sprite(make_sprite(32'h0010_0000, 32'h0008_0000, Q_HALF, Q_HALF, Q_ONE, Q_ONE,
                                0, 0, spq_pkg::ASPECT_ONE, 64'hF000_C000_4000_1000,
                                SPR_FLIP_Y, 16'h0001));
        send_sprite(make_sprite(32'h0010_0000, 32'h0008_0000, Q_HALF, Q_HALF, Q_ONE, Q_ONE,
                                0, 0, spq_pkg::ASPECT_ONE, 64'hF000_C000_4000_1000,
                                SPR_FLIP_X | SPR_FLIP_Y | SPR_LAST, 16'h0001));
        // Same handle after a list end opens a new batch.
        send_sprite(make_sprite(32'h0010_0000, 32'h0008_0000, Q_HALF, Q_HALF, Q_ONE, Q_ONE,
                                0, 0, spq_pkg::ASPECT_ONE, 64'h1234_5678_9ABC_DEF0, 3'b000,
                                16'h0001));
        // Height derived by division, from a positive and a negative width.
        send_sprite(make_sprite(32'h000A_0000, 0, Q_HALF, 0, Q_ONE, Q_ONE, 0, 0,
                                31'h0002_0000, 64'h0, 3'b000, 16'h0002));
        send_sprite(make_sprite(32'hFFF6_0000, 32'hFFFF_FFFF, Q_HALF, Q_HALF, Q_ONE, Q_ONE,
                                0, 0, 31'h0000_8000, 64'h0, 3'b000, 16'h0002));
        // Width derived by multiplication.
        send_sprite(make_sprite(0, 32'h0005_0000, Q_HALF, Q_HALF, Q_ONE, Q_ONE, 0, 0,
                                31'h0001_8000, 64'h0, 3'b000, 16'h0002));
        send_sprite(make_sprite(Q_MIN, Q_MAX, 0, 0, Q_ONE, Q_ONE, 0, 0,
                                ASPECT_MAX, 64'h0, 3'b000, 16'h0002));
        // Saturation at the positive and negative ends.
        send_sprite(make_sprite(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                ASPECT_MAX, 64'hFFFF_FFFF_FFFF_FFFF, SPR_FLIP_X, 16'hFFFF));
        send_sprite(make_sprite(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                31'h1, 64'h0, SPR_FLIP_Y, 16'hFFFF));
        send_sprite(make_sprite(Q_MAX, 32'hFFFF_FFFF, Q_MAX, Q_MAX, Q_ONE, Q_ONE, Q_MIN,
                                Q_MIN, 31'h1, 64'hAAAA_5555_AAAA_5555, 3'b000, 16'h8000));
        send_sprite(make_sprite(Q_ONE, Q_ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_0000, 32'hFFFF_0000, Q_MIN, Q_MAX,
                                spq_pkg::ASPECT_ONE, 64'h5555_AAAA_5555_AAAA,
                                SPR_LAST | SPR_FLIP_Y, 16'h8000));
        send_sprite(make_sprite(32'h1, 32'h1, Q_HALF, Q_HALF, Q_ONE, Q_ONE, 0, 0,
                                ASPECT_MAX, 64'h0001_0001_0001_0001, 3'b000, 16'h8000));
        send_sprite(make_sprite(32'hFFFF_0000, Q_ONE, 0, 0, Q_MAX, Q_MAX, 0, 0,
                                31'h1, 64'h8000_8000_8000_8000, 3'b000, 16'h0000));
        send_sprite(make_sprite(32'h0100_0000, 32'h0040_0000, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                                Q_ONE, Q_ONE, spq_pkg::ASPECT_ONE, 64'h7FFF_7FFF_7FFF_7FFF,
                                3'b111, 16'h0000));

        sent = 0;
        while (sent < RANDOM_ITEMS)
            send_random_list(sent);
        sprite_valid <= 1'b0;

        while (sb.expected_verts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d sprites and %0d vertices: %0d batches, %0d list ends",
                 sb.n_sprites, sb.n_verts, sb.n_batches, sb.n_lists);
        $display("heights derived %0d, widths derived %0d, vertex index wraps %0d, errors %0d",
                 sb.n_div, sb.n_mul, sb.n_wraps, sb.errors);
        if (sb.errors == 0)
            $display("PASS sprite_quad_generation");
        else
            $display("FAIL sprite_quad_generation");
        $finish;
    end

endmodule
